// File: design/uitf_pkg.sv
// ----------------------------------------------------------------------------
// uitf_pkg
// shared types and codes for the uart idle timeout framer
// ----------------------------------------------------------------------------
`default_nettype none

package uitf_pkg;

    localparam int BUFFER_DEPTH_DEF = 32;
    localparam int CMD_QDEPTH       = 4;
    localparam logic [7:0] IDLE_TICKS_RESET = 8'd5;

    // input item kinds
    localparam logic CMD_BYTE = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // front to back operations
    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_DUMP  = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_st;

endpackage

`default_nettype wire

// File: design/uitf_ram.sv
// ----------------------------------------------------------------------------
// uitf_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module uitf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic             i_re,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// File: design/uitf_front.sv
// ----------------------------------------------------------------------------
// uitf_front
// accepts bytes and ticks, tracks idle time and issues write and dump commands
// ----------------------------------------------------------------------------
`default_nettype none

module uitf_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire logic          i_cmd,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_cfg_we,
    input  wire logic [7:0]    i_cfg_wdata,
    input  wire uitf_pkg::t_q_st i_q_st,
    output logic               o_full,
    output logic               o_q_push,
    output uitf_pkg::t_cmd     o_q_cmd
);

    logic [7:0] r_thresh;
    logic [7:0] r_idle_cnt;
    logic       r_armed;
    logic [7:0] n_idle_cnt;
    logic       n_armed;
    logic [7:0] cnt_inc;
    logic       accept;
    logic       expire;

    assign accept  = i_push && !i_q_st.full;
    assign cnt_inc = r_idle_cnt + 8'd1;
    assign expire  = accept && (i_cmd == uitf_pkg::CMD_TICK) && r_armed
                     && !(cnt_inc < r_thresh);

    always_comb begin
        n_idle_cnt = r_idle_cnt;
        n_armed    = r_armed;
        if (accept) begin
            if (i_cmd == uitf_pkg::CMD_BYTE) begin
                n_idle_cnt = 8'd0;
                n_armed    = 1'b1;
            end else if (r_armed) begin
                if (expire) begin
                    n_idle_cnt = 8'd0;
                    n_armed    = 1'b0;
                end else begin
                    n_idle_cnt = cnt_inc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= uitf_pkg::IDLE_TICKS_RESET;
            r_idle_cnt <= 8'd0;
            r_armed    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thresh <= i_cfg_wdata;
            end
            r_idle_cnt <= n_idle_cnt;
            r_armed    <= n_armed;
        end
    end

    assign o_full       = i_q_st.full;
    assign o_q_push     = (accept && (i_cmd == uitf_pkg::CMD_BYTE)) || expire;
    assign o_q_cmd.op   = expire ? uitf_pkg::OP_DUMP : uitf_pkg::OP_WRITE;
    assign o_q_cmd.data = i_rx_byte;

endmodule

`default_nettype wire

// File: design/uitf_cmd_q.sv
// ----------------------------------------------------------------------------
// uitf_cmd_q
// short command queue between the front and the back
// ----------------------------------------------------------------------------
`default_nettype none

module uitf_cmd_q (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_push,
    input  wire uitf_pkg::t_cmd i_cmd,
    input  wire logic           i_pop,
    output uitf_pkg::t_q_st     o_st,
    output uitf_pkg::t_cmd      o_cmd
);

    localparam int QD  = uitf_pkg::CMD_QDEPTH;
    localparam int QAW = $clog2(QD);

    uitf_pkg::t_cmd r_slot [QD];
    logic [QAW-1:0] r_rd_ptr;
    logic [QAW-1:0] r_wr_ptr;
    logic [QAW:0]   r_cnt;
    logic           do_push;
    logic           do_pop;

    assign do_push = i_push && !o_st.full;
    assign do_pop  = i_pop && !o_st.empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_ptr <= '0;
            r_wr_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            r_cnt <= r_cnt + (QAW+1)'(do_push) - (QAW+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_st.empty = (r_cnt == '0);
    assign o_st.full  = (r_cnt == (QAW+1)'(QD));
    assign o_cmd      = r_slot[r_rd_ptr];

endmodule

`default_nettype wire

// File: design/uitf_back.sv
// ----------------------------------------------------------------------------
// uitf_back
// executes store writes and frame dumps, holds the result queue
// ----------------------------------------------------------------------------
`default_nettype none

module uitf_back #(
    parameter int BUFFER_DEPTH = uitf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire uitf_pkg::t_q_st i_q_st,
    input  wire uitf_pkg::t_cmd  i_q_cmd,
    output logic                 o_q_pop,
    input  wire logic            i_pop,
    output logic                 o_empty,
    output logic [7:0]           o_frame_byte,
    output logic                 o_frame_last
);

    localparam int AW = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(BUFFER_DEPTH - 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DUMP = 1'b1;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_beat;

    logic                    r_state;
    logic [AW-1:0]           r_widx;
    logic [AW-1:0]           r_raddr;
    logic [BUFFER_DEPTH-1:0] r_valid;
    logic                    r_rd_pend;
    logic                    r_rd_last;
    logic                    r_rd_vld;
    t_beat                   r_obuf [2];
    logic                    r_ohead;
    logic [1:0]              r_ocnt;

    logic                    n_state;
    logic [AW-1:0]           n_widx;
    logic [AW-1:0]           n_raddr;
    logic [BUFFER_DEPTH-1:0] n_valid;

    logic       do_write;
    logic       issue;
    logic       out_pop;
    logic       wpos;
    logic [7:0] ram_q;
    t_beat      beat;

    assign o_q_pop  = (r_state == ST_IDLE) && !i_q_st.empty;
    assign do_write = o_q_pop && (i_q_cmd.op == uitf_pkg::OP_WRITE);
    assign issue    = (r_state == ST_DUMP) && ((r_ocnt + {1'b0, r_rd_pend}) < 2'd2);
    assign out_pop  = i_pop && (r_ocnt != 2'd0);
    assign wpos     = r_ohead ^ r_ocnt[0];

    always_comb begin
        n_state = r_state;
        n_widx  = r_widx;
        n_raddr = r_raddr;
        n_valid = r_valid;
        unique case (r_state)
            ST_IDLE: begin
                if (o_q_pop) begin
                    if (i_q_cmd.op == uitf_pkg::OP_WRITE) begin
                        n_valid[r_widx] = 1'b1;
                        n_widx = (r_widx == LAST_ADDR) ? '0 : r_widx + 1'b1;
                    end else begin
                        n_widx  = '0;
                        n_raddr = '0;
                        n_state = ST_DUMP;
                    end
                end
            end
            ST_DUMP: begin
                if (issue) begin
                    n_valid[r_raddr] = 1'b0;
                    if (r_raddr == LAST_ADDR) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_raddr = r_raddr + 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_widx    <= '0;
            r_raddr   <= '0;
            r_valid   <= '0;
            r_rd_pend <= 1'b0;
            r_ohead   <= 1'b0;
            r_ocnt    <= 2'd0;
        end else begin
            r_state   <= n_state;
            r_widx    <= n_widx;
            r_raddr   <= n_raddr;
            r_valid   <= n_valid;
            r_rd_pend <= issue;
            if (out_pop) begin
                r_ohead <= ~r_ohead;
            end
            r_ocnt <= r_ocnt + {1'b0, r_rd_pend} - {1'b0, out_pop};
        end
    end

    // read side data travels with the registered ram output
    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_rd_last <= (r_raddr == LAST_ADDR);
            r_rd_vld  <= r_valid[r_raddr];
        end
        if (r_rd_pend) begin
            r_obuf[wpos] <= beat;
        end
    end

    assign beat.data = r_rd_vld ? ram_q : 8'h00;
    assign beat.last = r_rd_last;

    uitf_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (do_write),
        .i_waddr (r_widx),
        .i_wdata (i_q_cmd.data),
        .i_re    (issue),
        .i_raddr (r_raddr),
        .o_rdata (ram_q)
    );

    assign o_empty      = (r_ocnt == 2'd0);
    assign o_frame_byte = r_obuf[r_ohead].data;
    assign o_frame_last = r_obuf[r_ohead].last;

endmodule

`default_nettype wire

// File: design/uart_idle_timeout_framer_unit.sv
// ----------------------------------------------------------------------------
// uart_idle_timeout_framer_unit
// collects uart bytes into a circular store and dumps the whole store as a
// frame once the line has been idle for a set number of ticks
//
// channel   direction  handshake             beat
// input     in         i_push / o_full       i_cmd, i_rx_byte
// result    out        o_empty / i_pop       o_frame_byte, o_frame_last
// config    in         i_cfg_we              i_cfg_wdata (idle tick threshold)
//
// a byte or tick beat is taken by the front part while o_full is low
// a timeout dump reads every store entry in address order, paced by the
// two-beat output buffer: a store read issues only while buffered and
// in-flight beats number fewer than two
// up to four commands wait between front and back; o_full rises when they fill
// reset is synchronous; entry valid bits clear at once, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module uart_idle_timeout_framer_unit #(
    parameter int BUFFER_DEPTH = uitf_pkg::BUFFER_DEPTH_DEF
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    output logic            o_full,
    input  wire logic       i_cmd,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_frame_byte,
    output logic            o_frame_last,
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata
);

    uitf_pkg::t_q_st q_st;
    uitf_pkg::t_cmd  q_in_cmd;
    uitf_pkg::t_cmd  q_out_cmd;
    logic            q_push;
    logic            q_pop;

    uitf_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_q_st      (q_st),
        .o_full      (o_full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    uitf_cmd_q u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_st    (q_st),
        .o_cmd   (q_out_cmd)
    );

    uitf_back #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_q_st       (q_st),
        .i_q_cmd      (q_out_cmd),
        .o_q_pop      (q_pop),
        .i_pop        (i_pop),
        .o_empty      (o_empty),
        .o_frame_byte (o_frame_byte),
        .o_frame_last (o_frame_last)
    );

`ifndef NO_ASSERTIONS
    a_no_cmd_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_push |-> !q_st.full)
        else $error("command pushed into a full queue");

    a_no_cmd_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> !q_st.empty)
        else $error("command popped from an empty queue");

    a_empty_after_reset : assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");
`endif

endmodule

`default_nettype wire

// File: bench/tb_uart_idle_timeout_framer_unit.sv
// ----------------------------------------------------------------------------
// tb_uart_idle_timeout_framer_unit
// Self-checking bench for the uart idle timeout framer. Byte and tick beats
// go into the block while an in-bench copy of the framer state (store, write
// index, idle count, armed flag, tick threshold) predicts each frame dump.
// Every dump beat is compared with the oldest predicted beat. Runs directed
// frames, threshold edges, a long output stall with store wrap, and random
// frames with random gaps and stalls on both sides.
// ----------------------------------------------------------------------------
module tb_uart_idle_timeout_framer_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD   = 8;
    localparam int RESET_CYCLES = 9;
    localparam int DEPTH        = uitf_pkg::BUFFER_DEPTH_DEF;
    localparam int SETTLE_CYCLES = 40;
    localparam int END_CYCLES   = 2 * DEPTH + 20;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int RANDOM_ITEMS = 80;
    localparam int HOLD_CYCLES  = 400;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } t_dump_beat;

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_push;
    logic       o_full;
    logic       i_cmd;
    logic [7:0] i_rx_byte;
    logic       o_empty;
    logic       i_pop;
    logic [7:0] o_frame_byte;
    logic       o_frame_last;
    logic       i_cfg_we;
    logic [7:0] i_cfg_wdata;

    // predicted framer state
    logic [7:0]  mdl_store [DEPTH];
    int unsigned mdl_widx;
    logic [7:0]  mdl_idle;
    logic        mdl_armed;
    logic [7:0]  mdl_thr;

    t_dump_beat dump_q[$];
    int         mismatch_count = 0;
    int         items_sent     = 0;
    bit         src_idle       = 1'b0;
    bit         sink_idle      = 1'b0;
    int         sink_hold      = 0;

    uart_idle_timeout_framer_unit #(
        .BUFFER_DEPTH(DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (i_push),
        .o_full      (o_full),
        .i_cmd       (i_cmd),
        .i_rx_byte   (i_rx_byte),
        .o_empty     (o_empty),
        .i_pop       (i_pop),
        .o_frame_byte(o_frame_byte),
        .o_frame_last(o_frame_last),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // applies one accepted beat to the predicted state, returns 0 if ignored
    function automatic bit framer_accept(input logic cmd, input logic [7:0] data);
        t_dump_beat beat;
        if (cmd == uitf_pkg::CMD_BYTE) begin
            mdl_store[mdl_widx] = data;
            mdl_widx  = (mdl_widx + 1) % DEPTH;
            mdl_idle  = 8'd0;
            mdl_armed = 1'b1;
            return 1'b1;
        end
        if (!mdl_armed) begin
            return 1'b0;
        end
        mdl_idle = mdl_idle + 8'd1;
        if (mdl_idle >= mdl_thr) begin
            mdl_idle  = 8'd0;
            mdl_widx  = 0;
            mdl_armed = 1'b0;
            for (int k = 0; k < DEPTH; k++) begin
                beat.data = mdl_store[k];
                beat.last = (k == DEPTH - 1);
                dump_q.push_back(beat);
                mdl_store[k] = 8'd0;
            end
        end
        return 1'b1;
    endfunction

    task automatic send_beat(input logic cmd, input logic [7:0] data);
        if (src_idle && $urandom_range(0, 3) == 0) begin
            i_push <= 1'b0;
            repeat ($urandom_range(1, 14)) @(posedge i_clk);
        end
        i_push    <= 1'b1;
        i_cmd     <= cmd;
        i_rx_byte <= data;
        do @(posedge i_clk); while (o_full);
        if (framer_accept(cmd, data)) begin
            items_sent++;
        end
    endtask

    task automatic wait_frames_done();
        i_push <= 1'b0;
        while (dump_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_idle_ticks(input logic [7:0] ticks);
        wait_frames_done();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= ticks;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        mdl_thr = ticks;
    endtask

    task automatic close_frame();
        while (mdl_armed) send_beat(uitf_pkg::CMD_TICK, 8'($urandom));
    endtask

    // reset threshold, ignored ticks, restart of the idle count
    task automatic test_frame_basics();
        src_idle  = 1'b1;
        sink_idle = 1'b1;
        send_beat(uitf_pkg::CMD_TICK, 8'hFF);
        send_beat(uitf_pkg::CMD_BYTE, 8'h00);
        send_beat(uitf_pkg::CMD_BYTE, 8'hFF);
        send_beat(uitf_pkg::CMD_BYTE, 8'hA5);
        send_beat(uitf_pkg::CMD_BYTE, 8'h5A);
        repeat (4) send_beat(uitf_pkg::CMD_TICK, 8'h00);
        send_beat(uitf_pkg::CMD_BYTE, 8'h81);
        repeat (5) send_beat(uitf_pkg::CMD_TICK, 8'h00);
        send_beat(uitf_pkg::CMD_TICK, 8'h7E);
    endtask

    // zero, one and maximum tick thresholds
    task automatic test_threshold_edges();
        set_idle_ticks(8'd0);
        send_beat(uitf_pkg::CMD_BYTE, 8'h3C);
        send_beat(uitf_pkg::CMD_TICK, 8'h00);
        send_beat(uitf_pkg::CMD_TICK, 8'h00);
        set_idle_ticks(8'd1);
        send_beat(uitf_pkg::CMD_BYTE, 8'hC3);
        send_beat(uitf_pkg::CMD_BYTE, 8'h18);
        send_beat(uitf_pkg::CMD_TICK, 8'hFF);
        set_idle_ticks(8'd255);
        src_idle = 1'b0;
        send_beat(uitf_pkg::CMD_BYTE, 8'h7E);
        close_frame();
    endtask

    // long output stall so the block fills up, store wraps past its depth
    task automatic test_backpressure_wrap();
        set_idle_ticks(8'd2);
        src_idle  = 1'b0;
        sink_idle = 1'b0;
        sink_hold = HOLD_CYCLES;
        repeat (37) send_beat(uitf_pkg::CMD_BYTE, 8'($urandom));
        close_frame();
        repeat (4) send_beat(uitf_pkg::CMD_BYTE, 8'($urandom));
        close_frame();
        send_beat(uitf_pkg::CMD_BYTE, 8'($urandom));
        close_frame();
        repeat (2) send_beat(uitf_pkg::CMD_BYTE, 8'($urandom));
        close_frame();
        sink_idle = 1'b1;
    endtask

    task automatic test_random_frames();
        int base;
        int nbytes;
        base = items_sent;
        while (items_sent - base < RANDOM_ITEMS) begin
            if (items_sent - base > RANDOM_ITEMS * 4 / 5) begin
                src_idle  = 1'b0;
                sink_idle = 1'b0;
            end else begin
                src_idle  = ($urandom_range(0, 3) != 0);
                sink_idle = ($urandom_range(0, 3) != 0);
            end
            if ($urandom_range(0, 4) == 0) begin
                if ($urandom_range(0, 7) == 0)
                    set_idle_ticks(8'($urandom_range(0, 12)));
                else
                    set_idle_ticks(8'($urandom_range(1, 6)));
            end
            if (!mdl_armed && $urandom_range(0, 5) == 0) begin
                repeat ($urandom_range(1, 3)) send_beat(uitf_pkg::CMD_TICK, 8'($urandom));
            end
            nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 45)
                                                 : $urandom_range(1, 8);
            repeat (nbytes) begin
                send_beat(uitf_pkg::CMD_BYTE, 8'($urandom));
                if (mdl_thr > 8'd1 && $urandom_range(0, 5) == 0) begin
                    repeat ($urandom_range(1, mdl_thr - 1))
                        send_beat(uitf_pkg::CMD_TICK, 8'($urandom));
                end
            end
            if ($urandom_range(0, 9) != 0) begin
                close_frame();
            end
        end
        close_frame();
    endtask

    initial begin : sink
        int stall_left;
        stall_left = 0;
        i_pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (sink_hold > 0) begin
                i_pop <= 1'b0;
                sink_hold--;
            end else if (stall_left > 0) begin
                i_pop <= 1'b0;
                stall_left--;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                i_pop <= 1'b0;
                stall_left = $urandom_range(1, 14) - 1;
            end else begin
                i_pop <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin : frame_check
        t_dump_beat exp_beat;
        if (i_rst_n && i_pop && !o_empty) begin
            if (dump_q.size() == 0) begin
                $error("unexpected beat: frame_byte %0h frame_last %0b",
                       o_frame_byte, o_frame_last);
                mismatch_count++;
            end else begin
                exp_beat = dump_q.pop_front();
                if (o_frame_byte !== exp_beat.data) begin
                    $error("frame_byte expected %0h actual %0h", exp_beat.data, o_frame_byte);
                    mismatch_count++;
                end
                if (o_frame_last !== exp_beat.last) begin
                    $error("frame_last expected %0b actual %0b", exp_beat.last, o_frame_last);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        #20ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int waited;
        i_rst_n     <= 1'b0;
        i_push      <= 1'b0;
        i_cmd       <= uitf_pkg::CMD_BYTE;
        i_rx_byte   <= 8'd0;
        i_cfg_we    <= 1'b0;
        i_cfg_wdata <= 8'd0;
        foreach (mdl_store[k]) mdl_store[k] = 8'd0;
        mdl_widx  = 0;
        mdl_idle  = 8'd0;
        mdl_armed = 1'b0;
        mdl_thr   = uitf_pkg::IDLE_TICKS_RESET;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_frame_basics();
        test_threshold_edges();
        test_backpressure_wrap();
        test_random_frames();

        i_push <= 1'b0;
        waited = 0;
        while (dump_q.size() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge i_clk);
            waited++;
        end
        if (dump_q.size() != 0) begin
            $error("%0d frame beats never arrived", dump_q.size());
            mismatch_count++;
        end
        repeat (END_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
